// File: rtl/itoa_fmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_fmt_pkg;

    // Payload field widths
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int WIDTH_W = 7;
    localparam int PREC_W  = 6;
    localparam int SMODE_W = 2;
    localparam int CHAR_W  = 8;

    // Defaults for the top-level parameters
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;
    localparam int MAX_WIDTH_DEF  = 64;

    // Characters per number are capped at this count
    localparam int MAX_RESULTS = 64;
    localparam int POS_W       = $clog2(MAX_RESULTS + 1);
    // Layout arithmetic: lengths up to MAX_WIDTH + prefix + sign + MAX_DIGITS
    localparam int LEN_W       = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

    // sign_mode field codes
    localparam logic [SMODE_W-1:0] SMODE_PLUS  = 2'd1;
    localparam logic [SMODE_W-1:0] SMODE_SPACE = 2'd2;

    // Internal sign selection
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic lay1;
        logic lay2;
        logic fetch;
        logic put;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic conv_done;
        logic out_free;
        logic pend_last;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d, input logic uc);
        logic [CHAR_W-1:0] base;
        base = uc ? CH_UC_A : CH_LC_A;
        if (d < 6'd10) begin
            digit_char = CH_ZERO + CHAR_W'(d);
        end else begin
            digit_char = base + CHAR_W'(d) - CHAR_W'(10);
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/itoa_fmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  itoa_fmt_pkg::status_t status,
    output itoa_fmt_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_LAY1  = 3'd3;
    localparam logic [2:0] ST_LAY2  = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;
    localparam logic [2:0] ST_PUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = status.conv_done ? ST_LAY1 : ST_DIV;
            end
            ST_LAY1: begin
                cmd.lay1   = 1'b1;
                state_next = ST_LAY2;
            end
            ST_LAY2: begin
                cmd.lay2   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (status.out_free) begin
                    cmd.put    = 1'b1;
                    state_next = status.pend_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/itoa_fmt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_dp #(
    parameter int VALUE_BITS = itoa_fmt_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itoa_fmt_pkg::MAX_DIGITS_DEF,
    parameter int MAX_WIDTH  = itoa_fmt_pkg::MAX_WIDTH_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire [itoa_fmt_pkg::VALUE_W-1:0]       s_value,
    input  wire [itoa_fmt_pkg::RADIX_W-1:0]       s_radix,
    input  wire [itoa_fmt_pkg::WIDTH_W-1:0]       s_width,
    input  wire [itoa_fmt_pkg::PREC_W-1:0]        s_min_digits,
    input  wire                                   s_zero_pad,
    input  wire                                   s_signed_conv,
    input  wire [itoa_fmt_pkg::SMODE_W-1:0]       s_sign_mode,
    input  wire                                   s_left_align,
    input  wire                                   s_alt_prefix,
    input  wire                                   s_upper_case,
    input  itoa_fmt_pkg::cmd_t                    cmd,
    output itoa_fmt_pkg::status_t                 status,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [itoa_fmt_pkg::CHAR_W-1:0]       m_out_char,
    output logic                                  m_last
);

    localparam int AW    = $clog2(VALUE_BITS);
    localparam int NW    = $clog2(VALUE_BITS + 1);
    localparam int LEN_W = itoa_fmt_pkg::LEN_W;
    localparam int POS_W = itoa_fmt_pkg::POS_W;
    localparam int CW    = itoa_fmt_pkg::CHAR_W;
    localparam int RW    = itoa_fmt_pkg::RADIX_W;
    localparam int WW    = itoa_fmt_pkg::WIDTH_W;

    // Latched transaction fields
    logic [VALUE_BITS-1:0] quo_reg;
    logic [RW-1:0]         radix_reg;
    logic [WW-1:0]         width_reg;
    logic [WW-1:0]         prec_in_reg;
    logic                  zp_reg;
    logic                  left_reg;
    logic                  uc_reg;
    logic [1:0]            sign_reg;
    logic [1:0]            pfx_reg;

    // Divider
    logic [RW-1:0]         rem_reg;
    logic [AW-1:0]         bitcnt_reg;
    logic [NW-1:0]         n_reg;

    // Layout
    logic [LEN_W-1:0]      prec_reg;
    logic [WW-1:0]         padp_reg;
    logic [LEN_W-1:0]      b0_reg, b1_reg, b2_reg, b3_reg, b4_reg;
    logic [POS_W-1:0]      last_pos_reg;
    logic [POS_W-1:0]      pos_reg;

    // Fetch stage and output register
    logic [5:0]            digit_mem [VALUE_BITS];
    logic [5:0]            rd_data_reg;
    logic [CW-1:0]         pend_char_reg;
    logic                  pend_digit_reg;
    logic                  pend_last_reg;
    logic                  m_valid_reg;
    logic [CW-1:0]         out_char_reg;
    logic                  last_reg;

    // ---------------- load ----------------
    logic [VALUE_BITS-1:0] mag_raw;
    logic                  neg;
    logic [RW-1:0]         radix_cl;
    logic [WW-1:0]         width_cl;
    logic [WW-1:0]         prec_cl;
    logic [1:0]            sign_sel;
    logic [1:0]            pfx_sel;

    always_comb begin
        mag_raw  = VALUE_BITS'(s_value);
        neg      = s_signed_conv && mag_raw[VALUE_BITS-1];
        radix_cl = (s_radix < itoa_fmt_pkg::RADIX_MIN) ? itoa_fmt_pkg::RADIX_MIN :
                   (s_radix > itoa_fmt_pkg::RADIX_MAX) ? itoa_fmt_pkg::RADIX_MAX : s_radix;
        width_cl = (s_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : s_width;
        prec_cl  = (WW'(s_min_digits) > WW'(MAX_DIGITS)) ? WW'(MAX_DIGITS) : WW'(s_min_digits);
        sign_sel = itoa_fmt_pkg::SIGN_NONE;
        if (s_signed_conv) begin
            if (neg) begin
                sign_sel = itoa_fmt_pkg::SIGN_MINUS;
            end else if (s_sign_mode == itoa_fmt_pkg::SMODE_PLUS) begin
                sign_sel = itoa_fmt_pkg::SIGN_PLUS;
            end else if (s_sign_mode == itoa_fmt_pkg::SMODE_SPACE) begin
                sign_sel = itoa_fmt_pkg::SIGN_SPACE;
            end
        end
        pfx_sel = 2'd0;
        if (s_alt_prefix) begin
            if (radix_cl == itoa_fmt_pkg::RADIX_HEX) begin
                pfx_sel = 2'd2;
            end else if (radix_cl == itoa_fmt_pkg::RADIX_OCT) begin
                pfx_sel = 2'd1;
            end
        end
    end

    // ---------------- divider step ----------------
    logic [RW:0] trial;
    logic        ge;

    always_comb begin
        trial = {rem_reg, quo_reg[VALUE_BITS-1]};
        ge    = (trial >= {1'b0, radix_reg});
    end

    // ---------------- layout ----------------
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] prec_eff;
    logic [LEN_W:0]   pad_s;
    logic [LEN_W-1:0] sign_len;
    logic [LEN_W-1:0] padp_len;
    logic [LEN_W-1:0] lead, zpad, trail;
    logic [LEN_W-1:0] b1_c, b2_c, b4_c, total;

    always_comb begin
        n_len    = LEN_W'(n_reg);
        prec_eff = (LEN_W'(prec_in_reg) > n_len) ? LEN_W'(prec_in_reg) : n_len;
        sign_len = (sign_reg != itoa_fmt_pkg::SIGN_NONE) ? LEN_W'(1) : LEN_W'(0);
        pad_s    = (LEN_W + 1)'(width_reg) - (LEN_W + 1)'(sign_len)
                 - (LEN_W + 1)'(pfx_reg) - (LEN_W + 1)'(prec_eff);

        padp_len = LEN_W'(padp_reg);
        lead     = (!zp_reg && !left_reg) ? padp_len : '0;
        zpad     = zp_reg ? padp_len : '0;
        trail    = left_reg ? padp_len : '0;
        b1_c     = lead + sign_len;
        b2_c     = b1_c + LEN_W'(pfx_reg);
        b4_c     = b2_c + zpad + prec_reg;
        total    = b4_c + trail;
    end

    // ---------------- character select ----------------
    logic [LEN_W-1:0] pe;
    logic [LEN_W-1:0] daddr;
    logic [CW-1:0]    ch_sel;
    logic             is_digit;
    logic [CW-1:0]    sign_ch;

    always_comb begin
        pe    = LEN_W'(pos_reg);
        daddr = b4_reg - LEN_W'(1) - pe;
        case (sign_reg)
            itoa_fmt_pkg::SIGN_MINUS: sign_ch = itoa_fmt_pkg::CH_MINUS;
            itoa_fmt_pkg::SIGN_PLUS:  sign_ch = itoa_fmt_pkg::CH_PLUS;
            default:                  sign_ch = itoa_fmt_pkg::CH_SPACE;
        endcase
        is_digit = 1'b0;
        if (pe < b0_reg) begin
            ch_sel = itoa_fmt_pkg::CH_SPACE;
        end else if (pe < b1_reg) begin
            ch_sel = sign_ch;
        end else if (pe < b2_reg) begin
            if (pe == b1_reg) begin
                ch_sel = itoa_fmt_pkg::CH_ZERO;
            end else begin
                ch_sel = uc_reg ? itoa_fmt_pkg::CH_UC_X : itoa_fmt_pkg::CH_LC_X;
            end
        end else if (pe < b3_reg) begin
            ch_sel = itoa_fmt_pkg::CH_ZERO;
        end else if (pe < b4_reg) begin
            ch_sel   = itoa_fmt_pkg::CH_ZERO;
            is_digit = 1'b1;
        end else begin
            ch_sel = itoa_fmt_pkg::CH_SPACE;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quo_reg     <= neg ? (VALUE_BITS'(0) - mag_raw) : mag_raw;
            radix_reg   <= radix_cl;
            width_reg   <= width_cl;
            prec_in_reg <= prec_cl;
            zp_reg      <= s_zero_pad && !s_left_align;
            left_reg    <= s_left_align;
            uc_reg      <= s_upper_case;
            sign_reg    <= sign_sel;
            pfx_reg     <= pfx_sel;
            rem_reg     <= '0;
            bitcnt_reg  <= '0;
            n_reg       <= '0;
        end
        if (cmd.div_step) begin
            quo_reg    <= {quo_reg[VALUE_BITS-2:0], ge};
            rem_reg    <= ge ? RW'(trial - {1'b0, radix_reg}) : trial[RW-1:0];
            bitcnt_reg <= bitcnt_reg + AW'(1);
        end
        if (cmd.store) begin
            n_reg      <= n_reg + NW'(1);
            rem_reg    <= '0;
            bitcnt_reg <= '0;
        end
        if (cmd.lay1) begin
            prec_reg <= prec_eff;
            padp_reg <= pad_s[LEN_W] ? '0 : WW'(pad_s);
        end
        if (cmd.lay2) begin
            b0_reg       <= lead;
            b1_reg       <= b1_c;
            b2_reg       <= b2_c;
            b3_reg       <= b4_c - n_len;
            b4_reg       <= b4_c;
            last_pos_reg <= (total > LEN_W'(itoa_fmt_pkg::MAX_RESULTS)) ?
                            POS_W'(itoa_fmt_pkg::MAX_RESULTS - 1) : POS_W'(total - LEN_W'(1));
            pos_reg      <= '0;
        end
        if (cmd.fetch) begin
            pend_char_reg  <= ch_sel;
            pend_digit_reg <= is_digit;
            pend_last_reg  <= (pos_reg == last_pos_reg);
        end
        if (cmd.put) begin
            out_char_reg <= pend_digit_reg ? itoa_fmt_pkg::digit_char(rd_data_reg, uc_reg)
                                           : pend_char_reg;
            last_reg     <= pend_last_reg;
            pos_reg      <= pos_reg + POS_W'(1);
        end
    end

    // digit store: written per converted digit, read once per digit character
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            digit_mem[n_reg[AW-1:0]] <= rem_reg;
        end
        if (cmd.fetch && is_digit) begin
            rd_data_reg <= digit_mem[daddr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.put) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.div_last  = (bitcnt_reg == AW'(VALUE_BITS - 1));
    assign status.conv_done = (quo_reg == '0) || (n_reg == NW'(VALUE_BITS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.pend_last = pend_last_reg;

    assign m_valid    = m_valid_reg;
    assign m_out_char = out_char_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// printf-style integer formatter (%d/%u/%o/%x style, any base 2..36). One
// transaction on the s_ side carries a number and its format; the m_ side then
// delivers the text one ASCII character per transaction, m_last on the final
// one (at most 64 characters). Digits come from a bit-serial divider: one
// quotient bit a cycle, then a store step for the digit; at least one digit
// is always produced. The layout steps lay1 and lay2 follow, then each
// character is fetched and then loaded into the output register, waiting
// while that register is still full and m_ready is low. A new transaction is
// taken once the last character has been loaded into the output register, so
// its conversion overlaps the hand-off of that character.
module integer_to_ascii_formatter_core #(
    parameter int VALUE_BITS = itoa_fmt_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itoa_fmt_pkg::MAX_DIGITS_DEF,
    parameter int MAX_WIDTH  = itoa_fmt_pkg::MAX_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [itoa_fmt_pkg::VALUE_W-1:0]  s_value,
    input  wire [itoa_fmt_pkg::RADIX_W-1:0]  s_radix,
    input  wire [itoa_fmt_pkg::WIDTH_W-1:0]  s_width,
    input  wire [itoa_fmt_pkg::PREC_W-1:0]   s_min_digits,
    input  wire                              s_zero_pad,
    input  wire                              s_signed_conv,
    input  wire [itoa_fmt_pkg::SMODE_W-1:0]  s_sign_mode,
    input  wire                              s_left_align,
    input  wire                              s_alt_prefix,
    input  wire                              s_upper_case,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [itoa_fmt_pkg::CHAR_W-1:0]  m_out_char,
    output logic                             m_last
);

    itoa_fmt_pkg::cmd_t    cmd;
    itoa_fmt_pkg::status_t status;

    itoa_fmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itoa_fmt_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value       (s_value),
        .s_radix       (s_radix),
        .s_width       (s_width),
        .s_min_digits  (s_min_digits),
        .s_zero_pad    (s_zero_pad),
        .s_signed_conv (s_signed_conv),
        .s_sign_mode   (s_sign_mode),
        .s_left_align  (s_left_align),
        .s_alt_prefix  (s_alt_prefix),
        .s_upper_case  (s_upper_case),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last)
    );

    // one command at a time from the controller
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("controller issued overlapping commands");

    // a character is only loaded when the output register can take it
    a_put_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> (!m_valid || m_ready))
        else $error("output register overwritten before transaction");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again while converting");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && status.pend_last) |=> (s_ready && m_valid && m_last))
        else $error("final character did not return the block to idle");

endmodule

`default_nettype wire

// File: bench/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_core;
    import itoa_fmt_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;
    localparam int RAND_ITEMS = 286;

    // flag bits for building directed requests
    localparam int F_ZP    = 1;
    localparam int F_SC    = 2;
    localparam int F_PLUS  = 4;     // sign_mode bit 0
    localparam int F_SPACE = 8;     // sign_mode bit 1
    localparam int F_LEFT  = 16;
    localparam int F_ALT   = 32;
    localparam int F_UC    = 64;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [WIDTH_W-1:0] width;
        logic [PREC_W-1:0]  min_digits;
        logic               zero_pad;
        logic               signed_conv;
        logic [SMODE_W-1:0] sign_mode;
        logic               left_align;
        logic               alt_prefix;
        logic               upper_case;
    } num_req_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        int                item;
    } char_exp_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value = '0;
    logic [RADIX_W-1:0]  s_radix = RADIX_W'(10);
    logic [WIDTH_W-1:0]  s_width = '0;
    logic [PREC_W-1:0]   s_min_digits = '0;
    logic                s_zero_pad = 1'b0;
    logic                s_signed_conv = 1'b0;
    logic [SMODE_W-1:0]  s_sign_mode = '0;
    logic                s_left_align = 1'b0;
    logic                s_alt_prefix = 1'b0;
    logic                s_upper_case = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_out_char;
    logic                m_last;

    num_req_t  num_q [$];
    char_exp_t char_q [$];
    num_req_t  drv_req;
    char_exp_t mon_exp;
    int        n_taken = 0;
    int        n_errors = 0;
    int        n_chars = 0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        hold_left = 0;
    int        hold_cnt = 0;
    int        rx_mode = 0;
    int        rx_mode_left = 0;
    int        idle_cycles = 0;

    integer_to_ascii_formatter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_radix       (s_radix),
        .s_width       (s_width),
        .s_min_digits  (s_min_digits),
        .s_zero_pad    (s_zero_pad),
        .s_signed_conv (s_signed_conv),
        .s_sign_mode   (s_sign_mode),
        .s_left_align  (s_left_align),
        .s_alt_prefix  (s_alt_prefix),
        .s_upper_case  (s_upper_case),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_err(input string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Lays out the printf text of one number and queues its characters.
    function automatic void format_number(input num_req_t rq, input int idx);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [CHAR_W-1:0]  sgn;
        logic [5:0]         dig [32];
        logic [CHAR_W-1:0]  txt [$];
        logic               zp;
        int                 w, prec, pad, n, k, pfx, sgn_len;
        char_exp_t          e;
        base = VALUE_W'(rq.radix);
        if (base < 2) base = 2;
        if (base > 36) base = 36;
        w = int'(rq.width);
        if (w > 64) w = 64;
        prec = int'(rq.min_digits);
        if (prec > 32) prec = 32;
        zp = rq.zero_pad && !rq.left_align;
        mag = rq.value;
        sgn = '0;
        if (rq.signed_conv) begin
            if (mag[VALUE_W-1]) begin
                sgn = CH_MINUS;
                mag = -mag;
            end else if (rq.sign_mode == SMODE_PLUS) begin
                sgn = CH_PLUS;
            end else if (rq.sign_mode == SMODE_SPACE) begin
                sgn = CH_SPACE;
            end
        end
        sgn_len = (sgn != 0) ? 1 : 0;
        pfx = 0;
        if (rq.alt_prefix) begin
            if (base == 16) pfx = 2;
            else if (base == 8) pfx = 1;
        end
        n = 0;
        do begin
            dig[n] = 6'(mag % base);
            mag = mag / base;
            n++;
        end while (mag != 0 && n < 32);
        if (prec < n) prec = n;
        pad = w - sgn_len - pfx - prec;

        if (!zp && !rq.left_align) begin
            for (; pad > 0; pad--) txt.push_back(CH_SPACE);
        end
        if (sgn_len != 0) txt.push_back(sgn);
        if (pfx >= 1) txt.push_back(CH_ZERO);
        if (pfx == 2) txt.push_back(rq.upper_case ? CH_UC_X : CH_LC_X);
        if (!rq.left_align) begin
            for (; pad > 0; pad--) txt.push_back(CH_ZERO);
        end
        for (k = prec; k > n; k--) txt.push_back(CH_ZERO);
        for (k = n; k > 0; k--) begin
            if (dig[k-1] < 10)
                txt.push_back(CH_ZERO + CHAR_W'(dig[k-1]));
            else
                txt.push_back((rq.upper_case ? CH_UC_A : CH_LC_A) + CHAR_W'(dig[k-1]) - 8'd10);
        end
        for (; pad > 0; pad--) txt.push_back(CH_SPACE);

        for (k = 0; k < txt.size() && k < MAX_RESULTS; k++) begin
            e.ch = txt[k];
            e.last = (k == txt.size() - 1) || (k == MAX_RESULTS - 1);
            e.item = idx;
            char_q.push_back(e);
        end
    endfunction

    function automatic num_req_t mk_req(input logic [VALUE_W-1:0] v, input int rdx,
                                        input int wid, input int prec, input int fl);
        num_req_t rq;
        rq.value       = v;
        rq.radix       = RADIX_W'(rdx);
        rq.width       = WIDTH_W'(wid);
        rq.min_digits  = PREC_W'(prec);
        rq.zero_pad    = (fl & F_ZP) != 0;
        rq.signed_conv = (fl & F_SC) != 0;
        rq.sign_mode   = {(fl & F_SPACE) != 0, (fl & F_PLUS) != 0};
        rq.left_align  = (fl & F_LEFT) != 0;
        rq.alt_prefix  = (fl & F_ALT) != 0;
        rq.upper_case  = (fl & F_UC) != 0;
        return rq;
    endfunction

    function automatic num_req_t rand_req();
        num_req_t rq;
        case ($urandom_range(0, 5))
            0: rq.value = $urandom_range(0, 20);
            2: rq.value = 32'h8000_0000 ^ $urandom_range(0, 3);
            3: rq.value = ~VALUE_W'($urandom_range(0, 300));
            4: rq.value = $urandom_range(0, 99999);
            default: rq.value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: rq.radix = RADIX_W'(10);
            3:       rq.radix = RADIX_HEX;
            4:       rq.radix = RADIX_OCT;
            5:       rq.radix = RADIX_W'($urandom_range(0, 63));
            default: rq.radix = RADIX_W'($urandom_range(2, 36));
        endcase
        rq.width = ($urandom_range(0, 9) == 0) ? WIDTH_W'($urandom_range(0, 127))
                                               : WIDTH_W'($urandom_range(0, 16));
        rq.min_digits = ($urandom_range(0, 9) == 0) ? PREC_W'($urandom_range(0, 63))
                                                    : PREC_W'($urandom_range(0, 10));
        rq.zero_pad    = 1'($urandom_range(0, 1));
        rq.signed_conv = 1'($urandom_range(0, 1));
        rq.sign_mode   = SMODE_W'($urandom_range(0, 3));
        rq.left_align  = 1'($urandom_range(0, 1));
        rq.alt_prefix  = 1'($urandom_range(0, 1));
        rq.upper_case  = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    // everything offered has been taken and every character has come back
    task automatic wait_drained();
        while (num_q.size() != 0 || s_valid || char_q.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int i;
        num_q.push_back(mk_req(32'd0, 10, 0, 0, 0));
        num_q.push_back(mk_req(32'd0, 16, 0, 0, F_ALT));
        num_q.push_back(mk_req(32'd0, 8, 0, 0, F_ALT));
        num_q.push_back(mk_req(32'd0, 10, 0, 3, 0));
        num_q.push_back(mk_req(32'hFFFF_FFFF, 10, 0, 0, 0));
        num_q.push_back(mk_req(32'h8000_0000, 10, 0, 0, F_SC));
        num_q.push_back(mk_req(32'h7FFF_FFFF, 10, 0, 0, F_SC | F_PLUS));
        num_q.push_back(mk_req(32'd42, 10, 6, 0, F_SC | F_SPACE));
        num_q.push_back(mk_req(32'd42, 10, 6, 0, F_SC | F_PLUS | F_SPACE));
        num_q.push_back(mk_req(32'd42, 10, 6, 0, F_PLUS));
        num_q.push_back(mk_req(32'hFFFF_FFFF, 2, 0, 0, 0));
        num_q.push_back(mk_req(32'd5, 0, 0, 0, 0));
        num_q.push_back(mk_req(32'd5, 1, 4, 0, F_ZP));
        num_q.push_back(mk_req(32'hFFFF_FFFF, 63, 0, 0, F_UC));
        num_q.push_back(mk_req(32'd123456789, 37, 0, 0, 0));
        num_q.push_back(mk_req(32'hDEAD_BEEF, 16, 127, 0, F_LEFT | F_ALT | F_UC));
        num_q.push_back(mk_req(32'hFFFF_FF85, 10, 64, 0, F_SC | F_ZP));
        num_q.push_back(mk_req(32'd255, 16, 20, 10, F_ZP | F_ALT));
        num_q.push_back(mk_req(32'd7, 10, 0, 63, 0));
        num_q.push_back(mk_req(32'd77, 8, 12, 5, F_ZP | F_LEFT | F_ALT));
        num_q.push_back(mk_req(32'd77, 10, 0, 0, F_ALT));
        num_q.push_back(mk_req(32'h1234_5678, 16, 10, 0, F_ALT | F_ZP | F_SC | F_PLUS));
        num_q.push_back(mk_req(32'h8000_0000, 2, 127, 63,
                               F_SC | F_ZP | F_ALT | F_UC | F_PLUS | F_SPACE));
        num_q.push_back(mk_req(32'h0000_00AB, 16, 9, 0, F_LEFT | F_SC | F_SPACE));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < RAND_ITEMS / 2; i++) num_q.push_back(rand_req());
        wait_drained();
        for (i = RAND_ITEMS / 2; i < RAND_ITEMS; i++) num_q.push_back(rand_req());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // sender: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                format_number(drv_req, n_taken);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (num_q.size() != 0) begin
                    drv_req = num_q.pop_front();
                    s_value       <= drv_req.value;
                    s_radix       <= drv_req.radix;
                    s_width       <= drv_req.width;
                    s_min_digits  <= drv_req.min_digits;
                    s_zero_pad    <= drv_req.zero_pad;
                    s_signed_conv <= drv_req.signed_conv;
                    s_sign_mode   <= drv_req.sign_mode;
                    s_left_align  <= drv_req.left_align;
                    s_alt_prefix  <= drv_req.alt_prefix;
                    s_upper_case  <= drv_req.upper_case;
                    s_valid       <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                                 : $urandom_range(0, 6);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall patterns, plus two long hold-offs that back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_cnt < 2 && n_chars >= (hold_cnt == 0 ? 300 : 2000)) begin
            hold_cnt++;
            hold_left = 500;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // character checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (char_q.size() == 0) begin
                report_err($sformatf("unexpected char 0x%h last=%b", m_out_char, m_last));
            end else begin
                mon_exp = char_q.pop_front();
                if (m_out_char !== mon_exp.ch)
                    report_err($sformatf("item %0d char 0x%h, expected 0x%h",
                                         mon_exp.item, m_out_char, mon_exp.ch));
                if (m_last !== mon_exp.last)
                    report_err($sformatf("item %0d last %b, expected %b",
                                         mon_exp.item, m_last, mon_exp.last));
            end
            n_chars <= n_chars + 1;
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
